### rtl/core/wsd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
// Used by wsd_front, wsd_queue, wsd_back and the top level.
`timescale 1ns / 1ps

package wsd_pkg;

  localparam int LENGTH_BITS = 64;
  localparam int QDepth      = 4;
  localparam int QPtrBits    = $clog2(QDepth);

  localparam logic [LENGTH_BITS-1:0] LenMax = '1;

  localparam logic [6:0] Len16Code = 7'd126;
  localparam logic [6:0] Len64Code = 7'd127;

  localparam logic [3:0] OpClose = 4'h8;
  localparam logic [3:0] OpPing  = 4'h9;
  localparam logic [3:0] OpPong  = 4'ha;
  localparam logic [3:0] OpLastData = 4'h2;

  localparam logic [7:0] Newline = 8'h0a;

  localparam logic [3:0] ExtLen16Bytes = 4'd2;
  localparam logic [3:0] ExtLen64Bytes = 4'd8;
  localparam logic [3:0] KeyBytes      = 4'd4;

  localparam logic [0:0] RegUnmaskEnable = 1'd0;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXTLEN,
    PH_KEY,
    PH_PAYLOAD
  } phase_t;

  // One queued item: a payload or error result, a terminator, or both.
  typedef struct packed {
    logic [7:0] data;
    logic [3:0] opcode;
    logic       has_data;
    logic       has_term;
    logic       is_err;
  } qent_t;

  function automatic logic opcode_known(input logic [3:0] op);
    return (op <= OpLastData) || (op == OpClose) || (op == OpPing) || (op == OpPong);
  endfunction

endpackage

### rtl/core/wsd_front.sv
// Header parser: takes stream bytes, tracks frame state and queues results.
// Depends on wsd_pkg.
`timescale 1ns / 1ps

module wsd_front
  import wsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       unmask_enable,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       q_full,
  output logic       push,
  output qent_t      push_ent
);

  phase_t                 phase, phase_next;
  logic [3:0]             opcode, opcode_next;
  logic                   final_bit, final_next;
  logic                   masked, masked_next;
  logic [3:0]             left, left_next;
  logic [LENGTH_BITS-1:0] rem, rem_next;
  logic [31:0]            key, key_next;
  logic [1:0]             mask_index, mask_index_next;
  logic                   halted, halted_next;

  logic       take;
  logic       len_done;
  logic       hdr_done;
  logic       wants_term;
  logic [7:0] key_byte;

  assign in_ready   = halted | ~q_full;
  assign take       = in_valid & in_ready;
  assign wants_term = (opcode >= OpClose) | final_bit;

  always_comb begin
    unique case (mask_index)
      2'd0: key_byte = key[31:24];
      2'd1: key_byte = key[23:16];
      2'd2: key_byte = key[15:8];
      2'd3: key_byte = key[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HDR0;
      opcode     <= '0;
      final_bit  <= 1'b0;
      masked     <= 1'b0;
      left       <= '0;
      rem        <= '0;
      key        <= '0;
      mask_index <= '0;
      halted     <= 1'b0;
    end else begin
      phase      <= phase_next;
      opcode     <= opcode_next;
      final_bit  <= final_next;
      masked     <= masked_next;
      left       <= left_next;
      rem        <= rem_next;
      key        <= key_next;
      mask_index <= mask_index_next;
      halted     <= halted_next;
    end
  end

  always_comb begin
    phase_next      = phase;
    opcode_next     = opcode;
    final_next      = final_bit;
    masked_next     = masked;
    left_next       = left;
    rem_next        = rem;
    key_next        = key;
    mask_index_next = mask_index;
    halted_next     = halted;
    len_done        = 1'b0;
    hdr_done        = 1'b0;
    push            = 1'b0;
    push_ent        = '0;
    push_ent.opcode = opcode;

    if (take && !halted) begin
      unique case (phase)
        PH_HDR0: begin
          final_next      = in_byte[7];
          opcode_next     = in_byte[3:0];
          push_ent.opcode = in_byte[3:0];
          if (!opcode_known(in_byte[3:0])) begin
            push              = 1'b1;
            push_ent.has_data = 1'b1;
            push_ent.is_err   = 1'b1;
            halted_next       = 1'b1;
          end else begin
            phase_next = PH_HDR1;
          end
        end
        PH_HDR1: begin
          masked_next = in_byte[7];
          rem_next    = '0;
          if (in_byte[6:0] == Len16Code) begin
            phase_next = PH_EXTLEN;
            left_next  = ExtLen16Bytes;
          end else if (in_byte[6:0] == Len64Code) begin
            phase_next = PH_EXTLEN;
            left_next  = ExtLen64Bytes;
          end else begin
            rem_next = {{(LENGTH_BITS-7){1'b0}}, in_byte[6:0]};
            len_done = 1'b1;
          end
        end
        PH_EXTLEN: begin
          // saturate once the length no longer fits
          if (rem[LENGTH_BITS-1 -: 8] != 8'd0) begin
            rem_next = LenMax;
          end else begin
            rem_next = {rem[LENGTH_BITS-9:0], in_byte};
          end
          left_next = left - 4'd1;
          if (left_next == 4'd0) begin
            len_done = 1'b1;
          end
        end
        PH_KEY: begin
          key_next  = {key[23:0], in_byte};
          left_next = left - 4'd1;
          if (left_next == 4'd0) begin
            hdr_done = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          push              = 1'b1;
          push_ent.has_data = 1'b1;
          push_ent.data     = (masked && unmask_enable) ? (in_byte ^ key_byte) : in_byte;
          mask_index_next   = mask_index + 2'd1;
          rem_next          = rem - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
          if (rem_next == '0) begin
            phase_next        = PH_HDR0;
            push_ent.has_term = wants_term;
          end
        end
        default: begin
          phase_next = PH_HDR0;
        end
      endcase

      if (len_done) begin
        if (masked_next) begin
          phase_next = PH_KEY;
          left_next  = KeyBytes;
          key_next   = '0;
        end else begin
          hdr_done = 1'b1;
        end
      end

      // header complete: enter payload or close a zero-length frame
      if (hdr_done) begin
        mask_index_next = '0;
        if (rem_next != '0) begin
          phase_next = PH_PAYLOAD;
        end else begin
          phase_next        = PH_HDR0;
          push              = wants_term;
          push_ent.has_term = wants_term;
        end
      end
    end
  end

endmodule

### rtl/core/wsd_queue.sv
// Short register queue between the parser and the result emitter.
// Depends on wsd_pkg.
`timescale 1ns / 1ps

module wsd_queue
  import wsd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  qent_t push_ent,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output qent_t head
);

  qent_t               entries [QDepth];
  logic [QPtrBits-1:0] wr_ptr;
  logic [QPtrBits-1:0] rd_ptr;
  logic [QPtrBits:0]   count;

  assign full  = (count == QDepth[QPtrBits:0]);
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/core/wsd_back.sv
// Result emitter: expands each queued entry into one or two output items.
// Depends on wsd_pkg.
`timescale 1ns / 1ps

module wsd_back
  import wsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  qent_t      head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [3:0] frame_opcode,
  output logic       end_of_message,
  output logic       protocol_error,
  output logic       last
);

  logic term_phase, term_phase_next;
  logic show_term;
  logic fire;

  assign out_valid = ~q_empty;
  assign show_term = term_phase | ~head.has_data;
  assign fire      = out_valid & out_ready;

  always_comb begin
    frame_opcode = head.opcode;
    if (show_term) begin
      out_byte       = Newline;
      end_of_message = 1'b1;
      protocol_error = 1'b0;
      last           = 1'b1;
    end else begin
      out_byte       = head.data;
      end_of_message = 1'b0;
      protocol_error = head.is_err;
      last           = ~head.has_term;
    end
  end

  assign pop = fire & last;

  always_comb begin
    term_phase_next = term_phase;
    if (pop) begin
      term_phase_next = 1'b0;
    end else if (fire) begin
      term_phase_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      term_phase <= 1'b0;
    end else begin
      term_phase <= term_phase_next;
    end
  end

endmodule

### rtl/core/websocket_frame_deframer.sv
// WebSocket frame deframer top level: parser, 4-entry queue, emitter, APB register.
// Each result is written into the queue registers before it reaches the output.
// Throughput: one byte per cycle while the queue is not full; a byte that ends a
// terminated frame yields two items; the emitter drains one item per cycle while m_tready is high.
// Reset (rst, synchronous): parser to first header byte, queue empty, unmasking off.
// Depends on wsd_pkg, wsd_front, wsd_queue, wsd_back.
`timescale 1ns / 1ps

module websocket_frame_deframer
  import wsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // slave stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  // master stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tlast,
  output logic [5:0]  m_tuser,   // [3:0] frame_opcode, [4] end_of_message, [5] protocol_error
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       unmask_enable;
  logic       q_full;
  logic       q_empty;
  logic       push;
  logic       pop;
  qent_t      push_ent;
  qent_t      head;
  logic [3:0] frame_opcode;
  logic       end_of_message;
  logic       protocol_error;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegUnmaskEnable && paddr[1:0] == 2'd0) ?
                  {31'd0, unmask_enable} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      unmask_enable <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == RegUnmaskEnable && paddr[1:0] == 2'd0) begin
      unmask_enable <= pwdata[0];
    end
  end

  wsd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .unmask_enable (unmask_enable),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .in_byte       (s_tdata),
    .q_full        (q_full),
    .push          (push),
    .push_ent      (push_ent)
  );

  wsd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_ent (push_ent),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  wsd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .head           (head),
    .pop            (pop),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_byte       (m_tdata),
    .frame_opcode   (frame_opcode),
    .end_of_message (end_of_message),
    .protocol_error (protocol_error),
    .last           (m_tlast)
  );

  assign m_tuser = {protocol_error, end_of_message, frame_opcode};

endmodule

### tb/websocket_frame_deframer_tb.sv
// Self-checking bench for the byte-serial WebSocket deframer.
// Drives frames over the input stream, predicts every output item and checks it.
// Depends on wsd_pkg and the websocket_frame_deframer top level.
`timescale 1ns / 1ps

module websocket_frame_deframer_tb;
  import wsd_pkg::*;

  localparam int LimitCycles  = 500000;
  localparam int SettleCycles = 8;
  localparam int LongStall    = 200;
  localparam int ReportMax    = 10;

  localparam logic [3:0] OpCont   = 4'h0;
  localparam logic [3:0] OpText   = 4'h1;
  localparam logic [3:0] OpBinary = OpLastData;
  localparam logic [2:0] UnmaskAddr = {RegUnmaskEnable, 2'b00};

  typedef enum int {FORM7, FORM16, FORM64} len_form_t;

  typedef struct packed {
    logic [7:0] data;
    logic [3:0] opcode;
    logic       eom;
    logic       perr;
    logic       last;
  } deframe_res_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;   // [7:0] out_byte
  logic        m_tlast;
  logic [5:0]  m_tuser;   // [3:0] frame_opcode, [4] end_of_message, [5] protocol_error
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  websocket_frame_deframer uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Parser shadow state
  phase_t                 ph = PH_HDR0;
  logic [3:0]             op = 4'd0;
  logic                   fin = 1'b0;
  logic                   msk = 1'b0;
  logic [3:0]             hdr_left = 4'd0;
  logic [LENGTH_BITS-1:0] plen = '0;
  logic [31:0]            key = 32'd0;
  logic [1:0]             kidx = 2'd0;
  logic                   halted = 1'b0;
  logic                   unmask = 1'b0;

  deframe_res_t pending_results[$];
  deframe_res_t step_out[$];
  logic [7:0]   byte_q[$];

  int  n_fail = 0;
  int  n_sent = 0;
  int  cycle_count = 0;
  bit  idle_on = 1'b1;
  bit  stall_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LimitCycles) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic flag_error(input string msg);
    n_fail++;
    if (n_fail <= ReportMax) $display("ERROR: %s", msg);
  endtask

  function automatic logic op_is_known(input logic [3:0] opc);
    return opc inside {OpCont, OpText, OpBinary, OpClose, OpPing, OpPong};
  endfunction

  task automatic emit(input logic [7:0] d, input logic eom, input logic perr);
    step_out.push_back('{data: d, opcode: op, eom: eom, perr: perr, last: 1'b0});
  endtask

  // Enter payload, or close out a zero-length frame.
  task automatic finish_header();
    kidx = 2'd0;
    if (plen != '0) begin
      ph = PH_PAYLOAD;
    end else begin
      ph = PH_HDR0;
      if (op >= OpClose || fin) emit(Newline, 1'b1, 1'b0);
    end
  endtask

  task automatic finish_length();
    if (msk) begin
      ph = PH_KEY;
      hdr_left = KeyBytes;
      key = 32'd0;
    end else begin
      finish_header();
    end
  endtask

  task automatic parse_byte(input logic [7:0] b);
    logic [7:0] v;
    step_out.delete();
    if (!halted) begin
      case (ph)
        PH_HDR0: begin
          fin = b[7];
          op = b[3:0];
          if (!op_is_known(op)) begin
            emit(8'h00, 1'b0, 1'b1);
            halted = 1'b1;
          end else begin
            ph = PH_HDR1;
          end
        end
        PH_HDR1: begin
          msk = b[7];
          plen = '0;
          if (b[6:0] == Len16Code) begin
            ph = PH_EXTLEN;
            hdr_left = ExtLen16Bytes;
          end else if (b[6:0] == Len64Code) begin
            ph = PH_EXTLEN;
            hdr_left = ExtLen64Bytes;
          end else begin
            plen = LENGTH_BITS'(b[6:0]);
            finish_length();
          end
        end
        PH_EXTLEN: begin
          // saturate a length that does not fit
          if (plen[LENGTH_BITS-1 -: 8] != 8'd0) plen = LenMax;
          else plen = {plen[LENGTH_BITS-9:0], b};
          hdr_left = hdr_left - 4'd1;
          if (hdr_left == 4'd0) finish_length();
        end
        PH_KEY: begin
          key = {key[23:0], b};
          hdr_left = hdr_left - 4'd1;
          if (hdr_left == 4'd0) finish_header();
        end
        PH_PAYLOAD: begin
          v = b;
          if (msk && unmask) v = v ^ key[8 * (3 - kidx) +: 8];
          kidx = kidx + 2'd1;
          emit(v, 1'b0, 1'b0);
          plen = plen - 1'b1;
          if (plen == '0) begin
            ph = PH_HDR0;
            if (op >= OpClose || fin) emit(Newline, 1'b1, 1'b0);
          end
        end
        default: ph = PH_HDR0;
      endcase
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
    foreach (step_out[i]) pending_results.push_back(step_out[i]);
  endtask

  // Predict on every accepted input item, then check every accepted output item.
  always @(posedge clk) begin
    deframe_res_t got;
    deframe_res_t want;
    if (!rst && s_tvalid && s_tready) parse_byte(s_tdata);
    if (!rst && m_tvalid && m_tready) begin
      got = '{data: m_tdata, opcode: m_tuser[3:0], eom: m_tuser[4], perr: m_tuser[5],
              last: m_tlast};
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected item data=%h op=%h eom=%b err=%b last=%b",
                             got.data, got.opcode, got.eom, got.perr, got.last));
      end else begin
        want = pending_results.pop_front();
        if (got !== want)
          flag_error($sformatf({"item mismatch: expected data=%h op=%h eom=%b err=%b last=%b",
                                ", got data=%h op=%h eom=%b err=%b last=%b"},
                               want.data, want.opcode, want.eom, want.perr, want.last,
                               got.data, got.opcode, got.eom, got.perr, got.last));
      end
    end
  end

  // Receiver: random bursts of back-pressure, plus one long hold-off on request.
  initial begin : sink
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (stall_req) begin
        stall_req = 1'b0;
        hold = LongStall;
      end
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 7) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    n_sent++;
  endtask

  task automatic send_count(input int n);
    repeat (n) send_byte(byte_q.pop_front());
  endtask

  // Queue one frame; fill < 0 gives random payload bytes.
  task automatic make_frame(input logic f, input logic [3:0] opc, input logic m,
                            input int len, input len_form_t form, input int fill);
    logic [63:0] l64;
    l64 = 64'(len);
    byte_q.push_back({f, 3'($urandom), opc});
    case (form)
      FORM7: byte_q.push_back({m, l64[6:0]});
      FORM16: begin
        byte_q.push_back({m, Len16Code});
        byte_q.push_back(l64[15:8]);
        byte_q.push_back(l64[7:0]);
      end
      default: begin
        byte_q.push_back({m, Len64Code});
        for (int i = 7; i >= 0; i--) byte_q.push_back(l64[8 * i +: 8]);
      end
    endcase
    if (m) repeat (4) byte_q.push_back(8'($urandom));
    repeat (len) byte_q.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
  endtask

  task automatic rand_frame();
    int len;
    int pick;
    len_form_t form;
    logic [3:0] opc;
    pick = $urandom_range(0, 99);
    if (pick < 70) len = $urandom_range(0, 8);
    else if (pick < 96) len = $urandom_range(9, 40);
    else len = $urandom_range(120, 300);
    pick = $urandom_range(0, 9);
    if (len > 125) form = (pick < 7) ? FORM16 : FORM64;
    else form = (pick < 6) ? FORM7 : ((pick < 8) ? FORM16 : FORM64);
    case ($urandom_range(0, 5))
      0: opc = OpCont;
      1: opc = OpText;
      2: opc = OpBinary;
      3: opc = OpClose;
      4: opc = OpPing;
      default: opc = OpPong;
    endcase
    make_frame(1'($urandom_range(0, 1)), opc, 1'($urandom_range(0, 1)), len, form, -1);
    send_count(byte_q.size());
  endtask

  // Hold the input, let expected items drain, then let the parser settle.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic check_reg();
    logic [31:0] rd;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= UnmaskAddr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd !== {31'd0, unmask})
      flag_error($sformatf("unmask_enable read %h, expected %h", rd, {31'd0, unmask}));
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
    wait_idle();
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == UnmaskAddr) unmask = val[0];
    check_reg();
  endtask

  task automatic test_register_reset();
    check_reg();
  endtask

  // Every opcode, empty frames, fragments, both extended length forms.
  task automatic test_basic_frames();
    idle_on = 1'b1;
    make_frame(1'b1, OpText, 1'b0, 0, FORM7, -1);
    make_frame(1'b0, OpBinary, 1'b0, 1, FORM7, 8'h00);
    make_frame(1'b1, OpCont, 1'b0, 1, FORM7, 8'hff);
    make_frame(1'b0, OpClose, 1'b0, 1, FORM7, -1);
    make_frame(1'b0, OpPing, 1'b0, 0, FORM7, -1);
    make_frame(1'b1, OpPong, 1'b0, 0, FORM7, -1);
    make_frame(1'b0, OpText, 1'b0, 0, FORM16, -1);
    make_frame(1'b1, OpBinary, 1'b0, 1, FORM64, -1);
    send_count(byte_q.size());
    wait_idle();
  endtask

  task automatic test_unmask();
    reg_write(UnmaskAddr, 32'd1);
    make_frame(1'b1, OpText, 1'b1, 6, FORM7, -1);
    // header, key and three payload bytes, then turn unmasking off mid-frame
    send_count(9);
    reg_write(UnmaskAddr, 32'd0);
    send_count(byte_q.size());
    reg_write(UnmaskAddr, 32'd1);
    make_frame(1'b0, OpBinary, 1'b0, 2, FORM7, -1);
    make_frame(1'b1, OpPing, 1'b1, 0, FORM7, -1);
    send_count(byte_q.size());
    wait_idle();
  endtask

  task automatic test_random_frames();
    int goal;
    idle_on = 1'b1;
    for (int chunk = 0; chunk < 4; chunk++) begin
      reg_write(UnmaskAddr, {31'd0, chunk[0]});
      goal = n_sent + 120;
      while (n_sent < goal) rand_frame();
    end
    wait_idle();
  endtask

  // Receiver holds off while the sender keeps offering, so the block fills up.
  task automatic test_backpressure();
    int goal;
    idle_on = 1'b0;
    stall_req = 1'b1;
    goal = n_sent + 60;
    while (n_sent < goal) rand_frame();
    wait_idle();
  endtask

  task automatic test_no_idle();
    int goal;
    idle_on = 1'b0;
    reg_write(UnmaskAddr, 32'd1);
    goal = n_sent + 120;
    while (n_sent < goal) rand_frame();
    wait_idle();
  endtask

  // Unknown opcode flags once; later bytes are dropped. Must run last.
  task automatic test_protocol_error();
    logic [3:0] bad;
    do bad = 4'($urandom); while (op_is_known(bad));
    byte_q.push_back({1'($urandom), 3'($urandom), bad});
    byte_q.push_back({1'b1, 3'd0, OpText});
    byte_q.push_back(8'h01);
    byte_q.push_back(8'($urandom));
    send_count(byte_q.size());
    wait_idle();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_register_reset();
    test_basic_frames();
    test_unmask();
    test_random_frames();
    test_backpressure();
    test_no_idle();
    test_protocol_error();
    wait_idle();
    if (pending_results.size() != 0)
      flag_error($sformatf("%0d expected items never arrived", pending_results.size()));
    if (n_fail == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
